@@ rtl/core/wavp8_pkg.sv @@
// Shared constants and types for the 8-bit PCM WAV stream parser.
`default_nettype none
package wavp8_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [7:0]  SAMPLE_OFFSET = 8'd128;
  localparam logic [15:0] PCM_BITS      = 16'd8;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_NO_RIFF      = 3'd1,
    ERR_NO_WAVE      = 3'd2,
    ERR_NO_FMT       = 3'd3,
    ERR_BAD_CHANNELS = 3'd4,
    ERR_NOT_8BIT     = 3'd5,
    ERR_EARLY_END    = 3'd6,
    ERR_TRUNCATED    = 3'd7
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  left_sample;
    logic [7:0]  right_sample;
    logic        last_frame;
    logic [31:0] sample_rate;
    logic        stereo;
    logic [31:0] frame_count;
    err_t        error_code;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/wav_pcm8_stream_parser.sv @@
// Byte-serial parser for RIFF/WAVE files carrying 8-bit mono or stereo PCM.
//
// Input stream: one file byte per transaction on s_axis_tdata, s_axis_tlast
// on the file's last byte; the parser restarts from the RIFF tag after it.
// Output stream: at most one transaction per input byte. m_axis_tuser holds
// the kind (sample frame, header info, error), m_axis_tlast marks the last
// frame of the data chunk, m_axis_tdata the remaining fields.
// A result is registered: it appears in the output register in the cycle after
// the byte that causes it is accepted.
// Throughput: one byte per cycle while the output is not stalled; the parse
// state is updated in a single pass of logic per byte and the output register
// lets the next byte enter while a result is being taken.
// Stall: when a result waits in the output register and m_axis_tready is
// low, s_axis_tready drops and no byte is taken until the result leaves.
// Reset: clears the parse state to expect the RIFF tag and empties the
// output register; no clearing pass is needed.
`default_nettype none
module wav_pcm8_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  wire logic        s_axis_tlast,   // end_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] left_sample, [15:8] right_sample, [47:16] sample_rate, [48] stereo,
  // [80:49] frame_count, [83:81] error_code, [87:84] zero
  output logic [87:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last_frame
);
  import wavp8_pkg::*;

  localparam logic [3:0] PH_RIFF_TAG   = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE_TAG   = 4'd2;
  localparam logic [3:0] PH_FMT_TAG    = 4'd3;
  localparam logic [3:0] PH_FMT_SIZE   = 4'd4;
  localparam logic [3:0] PH_FMT_BODY   = 4'd5;
  localparam logic [3:0] PH_PAD        = 4'd6;
  localparam logic [3:0] PH_CHUNK_ID   = 4'd7;
  localparam logic [3:0] PH_CHUNK_SIZE = 4'd8;
  localparam logic [3:0] PH_SKIP_BODY  = 4'd9;
  localparam logic [3:0] PH_DATA_BODY  = 4'd10;
  localparam logic [3:0] PH_DONE       = 4'd11;
  localparam logic [3:0] PH_FAILED     = 4'd12;

  logic [3:0]  phase, phase_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] field_shift, field_shift_next;
  logic [15:0] channel_count, channel_count_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [31:0] rate_value, rate_value_next;
  logic        stereo_mode, stereo_mode_next;
  logic [7:0]  held_left, held_left_next;
  logic        pair_half, pair_half_next;
  logic [31:0] frames_left, frames_left_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic        pad_pending, pad_pending_next;
  logic        chunk_is_data, chunk_is_data_next;

  logic        accept;
  logic [7:0]  b;
  logic        eof;
  logic [31:0] word;
  logic [7:0]  smp;
  logic [31:0] frames_dec;
  logic        res_valid;
  result_t     res;
  result_t     out_reg;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign eof           = s_axis_tlast;
  assign word          = {b, field_shift[31:8]};
  assign smp           = b - SAMPLE_OFFSET;
  assign frames_dec    = (frames_left != 32'd0) ? frames_left - 32'd1 : frames_left;

  always_comb begin
    phase_next           = phase;
    bytes_remaining_next = bytes_remaining;
    field_shift_next     = field_shift;
    channel_count_next   = channel_count;
    bits_per_sample_next = bits_per_sample;
    rate_value_next      = rate_value;
    stereo_mode_next     = stereo_mode;
    held_left_next       = held_left;
    pair_half_next       = pair_half;
    frames_left_next     = frames_left;
    byte_pos_next        = byte_pos;
    pad_pending_next     = pad_pending;
    chunk_is_data_next   = chunk_is_data;
    res_valid            = 1'b0;
    res                  = '0;

    unique case (phase)
      PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_TAG, PH_FMT_SIZE,
      PH_CHUNK_ID, PH_CHUNK_SIZE: begin
        field_shift_next = word;
        if (byte_pos[1:0] != 2'd3) begin
          byte_pos_next = byte_pos + 8'd1;
        end else begin
          byte_pos_next = 8'd0;
          priority if (phase == PH_RIFF_TAG) begin
            if (word == TAG_RIFF) begin
              phase_next = PH_RIFF_SIZE;
            end else begin
              phase_next     = PH_FAILED;
              res.error_code = ERR_NO_RIFF;
            end
          end else if (phase == PH_RIFF_SIZE) begin
            phase_next = PH_WAVE_TAG;
          end else if (phase == PH_WAVE_TAG) begin
            if (word == TAG_WAVE) begin
              phase_next = PH_FMT_TAG;
            end else begin
              phase_next     = PH_FAILED;
              res.error_code = ERR_NO_WAVE;
            end
          end else if (phase == PH_FMT_TAG) begin
            if (word == TAG_FMT) begin
              phase_next = PH_FMT_SIZE;
            end else begin
              phase_next     = PH_FAILED;
              res.error_code = ERR_NO_FMT;
            end
          end else if (phase == PH_FMT_SIZE) begin
            bytes_remaining_next = word;
            pad_pending_next     = word[0];
            channel_count_next   = 16'd0;
            bits_per_sample_next = 16'd0;
            rate_value_next      = 32'd0;
            if (word == 32'd0) begin
              phase_next     = PH_FAILED;
              res.error_code = ERR_BAD_CHANNELS;
            end else begin
              phase_next = PH_FMT_BODY;
            end
          end else if (phase == PH_CHUNK_ID) begin
            chunk_is_data_next = (word == TAG_DATA);
            phase_next         = PH_CHUNK_SIZE;
          end else begin
            bytes_remaining_next = word;
            if (chunk_is_data) begin
              frames_left_next = stereo_mode ? {1'b0, word[31:1]} : word;
              pair_half_next   = 1'b0;
              res_valid        = 1'b1;
              res.kind         = KIND_HEADER;
              res.sample_rate  = rate_value;
              res.stereo       = stereo_mode;
              res.frame_count  = stereo_mode ? {1'b0, word[31:1]} : word;
              phase_next       = (word != 32'd0) ? PH_DATA_BODY : PH_DONE;
            end else begin
              pad_pending_next = word[0];
              phase_next       = (word != 32'd0) ? PH_SKIP_BODY : PH_CHUNK_ID;
            end
          end
        end
      end
      PH_FMT_BODY: begin
        unique case (byte_pos)
          8'd2:    channel_count_next[7:0]    = channel_count[7:0] | b;
          8'd3:    channel_count_next[15:8]   = channel_count[15:8] | b;
          8'd4:    rate_value_next[7:0]       = rate_value[7:0] | b;
          8'd5:    rate_value_next[15:8]      = rate_value[15:8] | b;
          8'd6:    rate_value_next[23:16]     = rate_value[23:16] | b;
          8'd7:    rate_value_next[31:24]     = rate_value[31:24] | b;
          8'd14:   bits_per_sample_next[7:0]  = bits_per_sample[7:0] | b;
          8'd15:   bits_per_sample_next[15:8] = bits_per_sample[15:8] | b;
          default: ;
        endcase
        if (byte_pos != 8'hFF) begin
          byte_pos_next = byte_pos + 8'd1;
        end
        bytes_remaining_next = bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          byte_pos_next = 8'd0;
          priority if (channel_count_next != 16'd1 && channel_count_next != 16'd2) begin
            phase_next     = PH_FAILED;
            res.error_code = ERR_BAD_CHANNELS;
          end else if (bits_per_sample_next != PCM_BITS) begin
            phase_next     = PH_FAILED;
            res.error_code = ERR_NOT_8BIT;
          end else begin
            stereo_mode_next = (channel_count_next == 16'd2);
            phase_next       = pad_pending ? PH_PAD : PH_CHUNK_ID;
          end
        end
      end
      PH_SKIP_BODY: begin
        bytes_remaining_next = bytes_remaining - 32'd1;
        if (bytes_remaining == 32'd1) begin
          phase_next = pad_pending ? PH_PAD : PH_CHUNK_ID;
        end
      end
      PH_PAD: begin
        phase_next = PH_CHUNK_ID;
      end
      PH_DATA_BODY: begin
        bytes_remaining_next = bytes_remaining - 32'd1;
        priority if (!stereo_mode) begin
          frames_left_next = frames_dec;
          res_valid        = 1'b1;
          res.kind         = KIND_FRAME;
          res.left_sample  = smp;
          res.right_sample = smp;
          res.last_frame   = (frames_dec == 32'd0);
        end else if (!pair_half) begin
          if (frames_left != 32'd0) begin
            held_left_next = smp;
            pair_half_next = 1'b1;
          end
        end else begin
          pair_half_next   = 1'b0;
          frames_left_next = frames_dec;
          res_valid        = 1'b1;
          res.kind         = KIND_FRAME;
          res.left_sample  = held_left;
          res.right_sample = smp;
          res.last_frame   = (frames_dec == 32'd0);
        end
        if (bytes_remaining == 32'd1) begin
          phase_next = PH_DONE;
        end
      end
      default: ;
    endcase

    if (res.error_code == ERR_NONE && eof) begin
      if (phase_next < PH_DATA_BODY) begin
        res.error_code = ERR_EARLY_END;
      end else if (phase_next == PH_DATA_BODY) begin
        res.error_code = ERR_TRUNCATED;
      end
    end
    if (res.error_code != ERR_NONE) begin
      res.kind         = KIND_ERROR;
      res.left_sample  = 8'd0;
      res.right_sample = 8'd0;
      res.last_frame   = 1'b0;
      res.sample_rate  = 32'd0;
      res.stereo       = 1'b0;
      res.frame_count  = 32'd0;
      res_valid        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_RIFF_TAG;
      bytes_remaining <= '0;
      field_shift     <= '0;
      channel_count   <= '0;
      bits_per_sample <= '0;
      rate_value      <= '0;
      stereo_mode     <= 1'b0;
      held_left       <= '0;
      pair_half       <= 1'b0;
      frames_left     <= '0;
      byte_pos        <= '0;
      pad_pending     <= 1'b0;
      chunk_is_data   <= 1'b0;
    end else if (accept) begin
      if (eof) begin
        phase           <= PH_RIFF_TAG;
        bytes_remaining <= '0;
        field_shift     <= '0;
        channel_count   <= '0;
        bits_per_sample <= '0;
        rate_value      <= '0;
        stereo_mode     <= 1'b0;
        held_left       <= '0;
        pair_half       <= 1'b0;
        frames_left     <= '0;
        byte_pos        <= '0;
        pad_pending     <= 1'b0;
        chunk_is_data   <= 1'b0;
      end else begin
        phase           <= phase_next;
        bytes_remaining <= bytes_remaining_next;
        field_shift     <= field_shift_next;
        channel_count   <= channel_count_next;
        bits_per_sample <= bits_per_sample_next;
        rate_value      <= rate_value_next;
        stereo_mode     <= stereo_mode_next;
        held_left       <= held_left_next;
        pair_half       <= pair_half_next;
        frames_left     <= frames_left_next;
        byte_pos        <= byte_pos_next;
        pad_pending     <= pad_pending_next;
        chunk_is_data   <= chunk_is_data_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tuser = out_reg.kind;
  assign m_axis_tlast = out_reg.last_frame;
  assign m_axis_tdata = {4'd0, out_reg.error_code, out_reg.frame_count, out_reg.stereo,
                         out_reg.sample_rate, out_reg.right_sample, out_reg.left_sample};

endmodule
`default_nettype wire

@@ verif/tb_wav_pcm8_stream_parser.sv @@
// Self-checking testbench for the byte-serial 8-bit PCM WAV stream parser.
`timescale 1ns / 1ps
module tb_wav_pcm8_stream_parser;
  import wavp8_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES = 220;

  typedef enum logic [3:0] {
    PH_RIFF_TAG   = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_TAG   = 4'd2,
    PH_FMT_TAG    = 4'd3,
    PH_FMT_SIZE   = 4'd4,
    PH_FMT_BODY   = 4'd5,
    PH_PAD        = 4'd6,
    PH_CHUNK_ID   = 4'd7,
    PH_CHUNK_SIZE = 4'd8,
    PH_SKIP_BODY  = 4'd9,
    PH_DATA_BODY  = 4'd10,
    PH_DONE       = 4'd11,
    PH_FAILED     = 4'd12
  } phase_t;

  typedef enum int {
    SPOIL_NONE = 0,
    SPOIL_RIFF = 1,
    SPOIL_WAVE = 2,
    SPOIL_FMT  = 3
  } spoil_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  wav_pcm8_stream_parser uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #6 clk = ~clk;

  file_byte_t  wav_bytes[$];
  logic [7:0]  build_buf[$];
  logic [7:0]  sample_script[$];
  result_t     results_due[$];

  int fault_count = 0;
  int bytes_taken = 0;
  int bytes_total = 0;
  int files_built = 0;
  int frames_seen = 0;
  int headers_seen = 0;
  int errors_seen = 0;
  int quiet_cycles = 0;

  phase_t      ph;
  logic [31:0] remain;
  logic [31:0] shift_word;
  logic [31:0] rate_acc;
  logic [31:0] frames_left;
  logic [15:0] chan_cnt;
  logic [15:0] bit_cnt;
  logic [7:0]  held_left;
  logic        is_stereo;
  logic        half;
  logic        pad_flag;
  logic        in_data;
  int unsigned pos;

  task automatic parser_restart();
    ph = PH_RIFF_TAG;
    remain = '0;
    shift_word = '0;
    rate_acc = '0;
    frames_left = '0;
    chan_cnt = '0;
    bit_cnt = '0;
    held_left = '0;
    is_stereo = 1'b0;
    half = 1'b0;
    pad_flag = 1'b0;
    in_data = 1'b0;
    pos = 0;
  endtask

  function automatic err_t accept_format();
    if (chan_cnt != 16'd1 && chan_cnt != 16'd2) begin
      ph = PH_FAILED;
      return ERR_BAD_CHANNELS;
    end
    if (bit_cnt != PCM_BITS) begin
      ph = PH_FAILED;
      return ERR_NOT_8BIT;
    end
    is_stereo = (chan_cnt == 16'd2);
    ph = pad_flag ? PH_PAD : PH_CHUNK_ID;
    return ERR_NONE;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    phase_t      cur;
    result_t     r;
    logic [31:0] w;
    logic [7:0]  s;
    logic        hit;
    err_t        e;
    cur = ph;
    r = '0;
    hit = 1'b0;
    e = ERR_NONE;
    s = b - SAMPLE_OFFSET;
    case (cur)
      PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_FMT_TAG, PH_FMT_SIZE, PH_CHUNK_ID,
      PH_CHUNK_SIZE: begin
        shift_word = {b, shift_word[31:8]};
        pos++;
        if (pos >= 4) begin
          w = shift_word;
          pos = 0;
          case (cur)
            PH_RIFF_TAG: begin
              if (w == TAG_RIFF) ph = PH_RIFF_SIZE;
              else begin
                ph = PH_FAILED;
                e = ERR_NO_RIFF;
              end
            end
            PH_RIFF_SIZE: ph = PH_WAVE_TAG;
            PH_WAVE_TAG: begin
              if (w == TAG_WAVE) ph = PH_FMT_TAG;
              else begin
                ph = PH_FAILED;
                e = ERR_NO_WAVE;
              end
            end
            PH_FMT_TAG: begin
              if (w == TAG_FMT) ph = PH_FMT_SIZE;
              else begin
                ph = PH_FAILED;
                e = ERR_NO_FMT;
              end
            end
            PH_FMT_SIZE: begin
              remain = w;
              pad_flag = w[0];
              chan_cnt = '0;
              bit_cnt = '0;
              rate_acc = '0;
              if (w == 32'd0) e = accept_format();
              else ph = PH_FMT_BODY;
            end
            PH_CHUNK_ID: begin
              in_data = (w == TAG_DATA);
              ph = PH_CHUNK_SIZE;
            end
            default: begin
              remain = w;
              if (in_data) begin
                frames_left = is_stereo ? (w >> 1) : w;
                half = 1'b0;
                r.kind = KIND_HEADER;
                r.sample_rate = rate_acc;
                r.stereo = is_stereo;
                r.frame_count = frames_left;
                hit = 1'b1;
                ph = (w != 32'd0) ? PH_DATA_BODY : PH_DONE;
              end else begin
                pad_flag = w[0];
                ph = (w != 32'd0) ? PH_SKIP_BODY : PH_CHUNK_ID;
              end
            end
          endcase
        end
      end
      PH_FMT_BODY: begin
        if (pos == 2 || pos == 3) chan_cnt[8*(pos-2) +: 8] = b;
        else if (pos >= 4 && pos <= 7) rate_acc[8*(pos-4) +: 8] = b;
        else if (pos == 14 || pos == 15) bit_cnt[8*(pos-14) +: 8] = b;
        if (pos < 255) pos++;
        remain--;
        if (remain == 32'd0) begin
          pos = 0;
          e = accept_format();
        end
      end
      PH_SKIP_BODY: begin
        remain--;
        if (remain == 32'd0) ph = pad_flag ? PH_PAD : PH_CHUNK_ID;
      end
      PH_PAD: ph = PH_CHUNK_ID;
      PH_DATA_BODY: begin
        remain--;
        if (!is_stereo) begin
          if (frames_left != 32'd0) frames_left--;
          r.kind = KIND_FRAME;
          r.left_sample = s;
          r.right_sample = s;
          r.last_frame = (frames_left == 32'd0);
          hit = 1'b1;
        end else if (!half) begin
          if (frames_left != 32'd0) begin
            held_left = s;
            half = 1'b1;
          end
        end else begin
          half = 1'b0;
          if (frames_left != 32'd0) frames_left--;
          r.kind = KIND_FRAME;
          r.left_sample = held_left;
          r.right_sample = s;
          r.last_frame = (frames_left == 32'd0);
          hit = 1'b1;
        end
        if (remain == 32'd0) ph = PH_DONE;
      end
      default: ;
    endcase
    if (e == ERR_NONE && eof) begin
      if (ph < PH_DATA_BODY) e = ERR_EARLY_END;
      else if (ph == PH_DATA_BODY) e = ERR_TRUNCATED;
    end
    if (e != ERR_NONE) begin
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = e;
      hit = 1'b1;
    end
    if (eof) parser_restart();
    if (hit) results_due.push_back(r);
  endtask

  task automatic report_fault(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    fault_count++;
    if (fault_count <= 50)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_result();
    result_t want;
    case (m_axis_tuser)
      KIND_FRAME:  frames_seen++;
      KIND_HEADER: headers_seen++;
      default:     errors_seen++;
    endcase
    if (results_due.size() == 0) begin
      report_fault("unexpected result kind", 32'(m_axis_tuser), 32'd0);
      return;
    end
    want = results_due.pop_front();
    if (m_axis_tuser !== want.kind)
      report_fault("kind", 32'(m_axis_tuser), 32'(want.kind));
    if (m_axis_tdata[7:0] !== want.left_sample)
      report_fault("left_sample", 32'(m_axis_tdata[7:0]), 32'(want.left_sample));
    if (m_axis_tdata[15:8] !== want.right_sample)
      report_fault("right_sample", 32'(m_axis_tdata[15:8]), 32'(want.right_sample));
    if (m_axis_tlast !== want.last_frame)
      report_fault("last_frame", 32'(m_axis_tlast), 32'(want.last_frame));
    if (m_axis_tdata[47:16] !== want.sample_rate)
      report_fault("sample_rate", m_axis_tdata[47:16], want.sample_rate);
    if (m_axis_tdata[48] !== want.stereo)
      report_fault("stereo", 32'(m_axis_tdata[48]), 32'(want.stereo));
    if (m_axis_tdata[80:49] !== want.frame_count)
      report_fault("frame_count", m_axis_tdata[80:49], want.frame_count);
    if (m_axis_tdata[83:81] !== want.error_code)
      report_fault("error_code", 32'(m_axis_tdata[83:81]), 32'(want.error_code));
    if (m_axis_tdata[87:84] !== 4'd0)
      report_fault("tdata padding", 32'(m_axis_tdata[87:84]), 32'd0);
  endtask

  // drive bytes, one gap drawn per transaction
  int         hold_off = 0;
  logic       drv_steady = 1'b0;
  file_byte_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (hold_off > 0) begin
          hold_off--;
          s_axis_tvalid <= 1'b0;
        end else if (wav_bytes.size() != 0) begin
          nxt = wav_bytes.pop_front();
          s_axis_tdata <= nxt.data;
          s_axis_tlast <= nxt.eof;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) drv_steady = !drv_steady;
          hold_off = drv_steady ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // take results, one stall drawn per transaction
  int   stall = 0;
  logic mon_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        if ($urandom_range(0, 39) == 0) mon_steady = !mon_steady;
        stall = mon_steady ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) build_buf.push_back(w[8*i +: 8]);
  endtask

  function automatic logic [31:0] maybe_spoil(input logic [31:0] tag, input bit hit);
    return hit ? tag ^ (32'd1 << $urandom_range(0, 31)) : tag;
  endfunction

  task automatic emit_file(input int cut_at);
    if (cut_at >= 0 && cut_at < build_buf.size()) build_buf = build_buf[0:cut_at];
    foreach (build_buf[i])
      wav_bytes.push_back('{data: build_buf[i], eof: (i == build_buf.size() - 1)});
    files_built++;
  endtask

  task automatic make_file(input spoil_t spoil, input logic [15:0] chans,
                           input logic [15:0] bits, input logic [31:0] rate,
                           input int fmt_len, input int n_skip, input logic [31:0] declared,
                           input int data_len, input int trailing, input int cut_at);
    logic [31:0] id;
    logic [7:0]  fb;
    int          skip_len;
    build_buf.delete();
    put_word(maybe_spoil(TAG_RIFF, spoil == SPOIL_RIFF));
    put_word($urandom);
    put_word(maybe_spoil(TAG_WAVE, spoil == SPOIL_WAVE));
    put_word(maybe_spoil(TAG_FMT, spoil == SPOIL_FMT));
    put_word(fmt_len);
    for (int i = 0; i < fmt_len; i++) begin
      case (i)
        0:          fb = 8'd1;
        1:          fb = 8'd0;
        2, 3:       fb = chans[8*(i-2) +: 8];
        4, 5, 6, 7: fb = rate[8*(i-4) +: 8];
        14, 15:     fb = bits[8*(i-14) +: 8];
        default:    fb = 8'($urandom);
      endcase
      build_buf.push_back(fb);
    end
    if (fmt_len % 2) build_buf.push_back(8'($urandom));
    repeat (n_skip) begin
      id = $urandom;
      if (id == TAG_DATA) id = ~id;
      skip_len = $urandom_range(0, 9);
      put_word(id);
      put_word(skip_len);
      repeat (skip_len + skip_len % 2) build_buf.push_back(8'($urandom));
    end
    put_word(TAG_DATA);
    put_word(declared);
    repeat (data_len)
      build_buf.push_back(sample_script.size() != 0 ? sample_script.pop_front()
                                                    : 8'($urandom));
    repeat (trailing) build_buf.push_back(8'($urandom));
    emit_file(cut_at);
  endtask

  task automatic make_random_file();
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] declared;
    int          pick;
    int          fmt_len;
    int          data_len;
    spoil_t      spoil;
    int          cut_at;
    pick = $urandom_range(0, 99);
    chans = (pick < 45) ? 16'd1 : (pick < 90) ? 16'd2 : 16'($urandom);
    bits = ($urandom_range(0, 19) == 0) ? 16'($urandom) : PCM_BITS;
    pick = $urandom_range(0, 9);
    fmt_len = (pick < 7) ? 16 : (pick < 9) ? 18 : $urandom_range(0, 24);
    if ($urandom_range(0, 19) == 0) begin
      declared = $urandom;
      data_len = $urandom_range(0, 10);
    end else begin
      declared = $urandom_range(0, 40);
      data_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, declared) : declared;
    end
    spoil = ($urandom_range(0, 24) == 0) ? spoil_t'($urandom_range(1, 3)) : SPOIL_NONE;
    cut_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 60) : -1;
    make_file(spoil, chans, bits, $urandom, fmt_len, $urandom_range(0, 2), declared,
              data_len, $urandom_range(0, 3), cut_at);
  endtask

  task automatic make_noise();
    build_buf.delete();
    if ($urandom_range(0, 1)) put_word(TAG_RIFF);
    repeat ($urandom_range(1, 8)) build_buf.push_back(8'($urandom));
    emit_file(-1);
  endtask

  initial begin
    int random_start;
    parser_restart();

    sample_script = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01};
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'hFFFF_FFFF, 16, 0, 32'd5, 5, 0, -1);
    sample_script = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h42};
    make_file(SPOIL_NONE, 16'd2, PCM_BITS, 32'd0, 18, 2, 32'd5, 5, 2, -1);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd44100, 16, 1, 32'd0, 0, 1, -1);
    make_file(SPOIL_NONE, 16'd2, PCM_BITS, 32'd22050, 15, 0, 32'd4, 4, 0, -1);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd8000, 2, 0, 32'd4, 4, 0, -1);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd8000, 0, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_NONE, 16'd0, PCM_BITS, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_NONE, 16'hFFFF, 16'h0000, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_NONE, 16'd2, 16'h0108, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_NONE, 16'd1, 16'd16, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_RIFF, 16'd1, PCM_BITS, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_WAVE, 16'd1, PCM_BITS, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_FMT, 16'd1, PCM_BITS, 32'd8000, 16, 0, 32'd2, 2, 0, -1);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd8000, 16, 0, 32'd4, 4, 0, 20);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd8000, 16, 0, 32'd4, 4, 0, 0);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd11025, 16, 0, 32'd3, 3, 0, 43);
    make_file(SPOIL_NONE, 16'd2, PCM_BITS, 32'd48000, 16, 0, 32'hFFFF_FFFF, 4, 0, -1);
    make_file(SPOIL_NONE, 16'd1, PCM_BITS, 32'd16000, 16, 0, 32'd10, 3, 0, -1);

    random_start = wav_bytes.size();
    while (wav_bytes.size() - random_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) make_noise();
      else make_random_file();
    end
    bytes_total = wav_bytes.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (results_due.size() != 0)
      report_fault("results never delivered", 32'd0, results_due.size());
    $display("ran %0d files and noise runs, %0d bytes in, %0d faults",
             files_built, bytes_taken, fault_count);
    $display("results by kind: %0d sample frames, %0d header infos, %0d errors",
             frames_seen, headers_seen, errors_seen);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
